### hw/rtl/abfp_pkg.sv
// Shared types, codes and helpers of the attractor basin fate predictor.
package abfp_pkg;

  localparam int MAX_ATTRACTORS_DEF = 8;
  localparam int FRAC_BITS_DEF      = 24;

  localparam logic [30:0] SMAX31 = 31'h7fff_ffff;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_TICK   = 3'd0,
    REG_RADIUS = 3'd1,
    REG_DRAG   = 3'd2,
    REG_FORCE  = 3'd3,
    REG_COUNT  = 3'd4,
    REG_LIMIT  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [30:0] tick;
    logic [30:0] radius;
    logic [24:0] drag;
    logic [30:0] force_k;
    logic [3:0]  count;
    logic [15:0] limit;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STEP,
    ST_V2,
    ST_ATTR,
    ST_DIR,
    ST_SQD,
    ST_CHECK,
    ST_MAGW,
    ST_SCALE,
    ST_PMUL,
    ST_PDIV,
    ST_PWAIT,
    ST_DRAG,
    ST_MOVE,
    ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_WRITE,
    OP_LOAD,
    OP_SQ_V,
    OP_RD,
    OP_DIR,
    OP_SQ_D,
    OP_START,
    OP_MAG_SAVE,
    OP_SCALE,
    OP_PUSH_MUL,
    OP_DIV_PUSH,
    OP_PUSH_APPLY,
    OP_DRAG,
    OP_MOVE,
    OP_RES_HIT,
    OP_RES_MISS
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] k;
  } cmd_t;

  typedef struct packed {
    logic capt;
    logic szero;
    logic div_done;
    logic sqrt_done;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (v < -66'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

### hw/rtl/abfp_div.sv
// Restoring radix-2 divider, 64-bit dividend by 32-bit divisor, one bit a cycle.
module abfp_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic [63:0] quo,
  output logic        done
);
  localparam int NB = 64;
  localparam int CB = $clog2(NB);

  logic [31:0]   rem_r, rem_nxt;
  logic [63:0]   quo_r, quo_nxt;
  logic [31:0]   den_r;
  logic [CB-1:0] cnt_r;
  logic          run_r, done_r;
  logic [32:0]   tr;
  logic          ge;

  always_comb begin
    tr      = {rem_r, quo_r[NB-1]};
    ge      = tr >= {1'b0, den_r};
    rem_nxt = ge ? 32'(tr - {1'b0, den_r}) : tr[31:0];
    quo_nxt = {quo_r[NB-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CB'(NB - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && !start) |=> (done_r && $stable(quo_r)))
    else $error("divider result changed without a new start");

endmodule

### hw/rtl/abfp_sqrt.sv
// Integer square root of a 64-bit value, two radicand bits a cycle.
module abfp_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] val,
  output logic [31:0] root,
  output logic        done
);
  localparam int NI = 32;
  localparam int CB = $clog2(NI);

  logic [32:0]   rem_r;
  logic [31:0]   root_r;
  logic [63:0]   src_r;
  logic [CB-1:0] cnt_r;
  logic          run_r, done_r;
  logic [34:0]   tr, trial;
  logic          ge;

  always_comb begin
    tr    = {rem_r, src_r[63:62]};
    trial = {1'b0, root_r, 2'b01};
    ge    = tr >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CB'(NI - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      root_r <= '0;
      src_r  <= val;
    end else if (run_r) begin
      rem_r  <= ge ? 33'(tr - trial) : tr[32:0];
      root_r <= {root_r[30:0], ge};
      src_r  <= {src_r[61:0], 2'b00};
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule

### hw/rtl/abfp_dp.sv
// Datapath: attractor table, particle state, shared multiplier, divider and root unit.
module abfp_dp
  import abfp_pkg::*;
#(
  parameter int MAX_ATTRACTORS = MAX_ATTRACTORS_DEF,
  parameter int FRAC_BITS      = FRAC_BITS_DEF,
  localparam int IW = (MAX_ATTRACTORS > 1) ? $clog2(MAX_ATTRACTORS) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  input  logic [IW-1:0]       rd_addr,
  input  cfg_t                cfg,
  input  logic [2:0]          in_slot,
  input  logic signed [31:0]  in_x,
  input  logic signed [31:0]  in_y,
  input  logic signed [31:0]  in_z,
  input  logic [31:0]         in_color,
  output logic [31:0]         out_color,
  output logic                out_captured,
  output status_t             status
);
  localparam logic [31:0] SOFTEN =
    32'(((64'd3 << FRAC_BITS) + 64'd50) / 64'd100);

  logic signed [31:0] mem_x [MAX_ATTRACTORS];
  logic signed [31:0] mem_y [MAX_ATTRACTORS];
  logic signed [31:0] mem_z [MAX_ATTRACTORS];
  logic [31:0]        mem_c [MAX_ATTRACTORS];

  logic signed [31:0] ent_x_r, ent_y_r, ent_z_r;
  logic [31:0]        ent_c_r;
  logic signed [31:0] p_r [3];
  logic signed [31:0] v_r [3];
  logic signed [31:0] d_r [3];
  logic [63:0]        acc_r;
  logic [30:0]        v2_r, mag_r, s_r;
  logic signed [65:0] prod_r;
  logic [31:0]        out_color_r;
  logic               out_cap_r;

  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  logic signed [65:0] prod_sh;
  logic [63:0]        acc_sum, acc_sh, sum_sh;
  logic [30:0]        d2;
  logic signed [32:0] dabs;
  logic               wr_en;
  logic               div_start, sqrt_start;
  logic [63:0]        div_num, div_q;
  logic [31:0]        div_den, len;
  logic               div_done, sqrt_done;
  logic signed [65:0] v_ext, inc_ext;

  assign wr_en = int'(in_slot) < MAX_ATTRACTORS;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_WRITE && wr_en) begin
      mem_x[IW'(in_slot)] <= in_x;
      mem_y[IW'(in_slot)] <= in_y;
      mem_z[IW'(in_slot)] <= in_z;
      mem_c[IW'(in_slot)] <= in_color;
    end
    if (cmd.op == OP_RD) begin
      ent_x_r <= mem_x[rd_addr];
      ent_y_r <= mem_y[rd_addr];
      ent_z_r <= mem_z[rd_addr];
      ent_c_r <= mem_c[rd_addr];
    end
  end

  // Shared multiplier operand selection.
  always_comb begin
    dabs = d_r[cmd.k][31] ? -{d_r[cmd.k][31], d_r[cmd.k]} : {1'b0, d_r[cmd.k]};
    case (cmd.op)
      OP_SQ_V: begin
        ma = 33'(v_r[cmd.k]);
        mb = 33'(v_r[cmd.k]);
      end
      OP_SQ_D: begin
        ma = 33'(d_r[cmd.k]);
        mb = 33'(d_r[cmd.k]);
      end
      OP_SCALE: begin
        ma = {2'b00, cfg.tick};
        mb = {2'b00, mag_r};
      end
      OP_PUSH_MUL: begin
        ma = {2'b00, s_r};
        mb = dabs;
      end
      OP_DRAG: begin
        ma = 33'(v_r[cmd.k]);
        mb = {8'd0, cfg.drag};
      end
      OP_MOVE: begin
        ma = 33'(v_r[cmd.k]);
        mb = {2'b00, cfg.tick};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    prod    = ma * mb;
    prod_sh = prod >>> FRAC_BITS;
  end

  always_comb begin
    acc_sum = ((cmd.k == 2'd0) ? 64'd0 : acc_r) + prod[63:0];
    sum_sh  = acc_sum >> FRAC_BITS;
    acc_sh  = acc_r >> FRAC_BITS;
    d2      = (acc_sh > 64'(SMAX31)) ? SMAX31 : acc_sh[30:0];
    v_ext   = 66'(v_r[cmd.k]);
    inc_ext = {2'b00, div_q};
  end

  always_comb begin
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    div_num    = prod_r[63:0];
    div_den    = len;
    case (cmd.op)
      OP_START: begin
        div_start  = 1'b1;
        sqrt_start = 1'b1;
        div_num    = 64'(cfg.force_k) << FRAC_BITS;
        div_den    = 32'(d2) + SOFTEN;
      end
      OP_DIV_PUSH: begin
        div_start = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        p_r[0] <= in_x;
        p_r[1] <= in_y;
        p_r[2] <= in_z;
        v_r[0] <= '0;
        v_r[1] <= '0;
        v_r[2] <= '0;
      end
      OP_SQ_V: begin
        acc_r <= acc_sum;
        if (cmd.k == 2'd2) begin
          v2_r <= (sum_sh > 64'(SMAX31)) ? SMAX31 : sum_sh[30:0];
        end
      end
      OP_DIR: begin
        d_r[0] <= sat32(66'(ent_x_r) - 66'(p_r[0]));
        d_r[1] <= sat32(66'(ent_y_r) - 66'(p_r[1]));
        d_r[2] <= sat32(66'(ent_z_r) - 66'(p_r[2]));
      end
      OP_SQ_D:     acc_r <= acc_sum;
      OP_MAG_SAVE: mag_r <= (div_q > 64'(SMAX31)) ? SMAX31 : div_q[30:0];
      OP_SCALE:    s_r <= (prod_sh > 66'(SMAX31)) ? SMAX31 : prod_sh[30:0];
      OP_PUSH_MUL: prod_r <= prod;
      OP_PUSH_APPLY: begin
        v_r[cmd.k] <= d_r[cmd.k][31] ? sat32(v_ext - inc_ext) : sat32(v_ext + inc_ext);
      end
      OP_DRAG: v_r[cmd.k] <= sat32(prod_sh);
      OP_MOVE: p_r[cmd.k] <= sat32(66'(p_r[cmd.k]) + prod_sh);
      OP_RES_HIT: begin
        out_color_r <= ent_c_r;
        out_cap_r   <= 1'b1;
      end
      OP_RES_MISS: begin
        out_color_r <= '0;
        out_cap_r   <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  abfp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_q),
    .done  (div_done)
  );

  abfp_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .val   (acc_r),
    .root  (len),
    .done  (sqrt_done)
  );

  assign status.capt      = (d2 < cfg.radius) && (v2_r < cfg.force_k);
  assign status.szero     = (acc_r == 64'd0);
  assign status.div_done  = div_done;
  assign status.sqrt_done = sqrt_done;
  assign out_color        = out_color_r;
  assign out_captured     = out_cap_r;

endmodule

### hw/rtl/abfp_ctrl.sv
// Controller: sequences steps, attractor visits and result hand-off.
module abfp_ctrl
  import abfp_pkg::*;
#(
  parameter int MAX_ATTRACTORS = MAX_ATTRACTORS_DEF,
  localparam int IW = (MAX_ATTRACTORS > 1) ? $clog2(MAX_ATTRACTORS) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic          in_mode,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  cfg_t          cfg,
  input  status_t       status,
  output cmd_t          cmd,
  output logic [IW-1:0] rd_addr
);
  localparam int CW = $clog2(MAX_ATTRACTORS + 1);

  state_t        state_r, state_nxt;
  logic [1:0]    k_r, k_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [15:0]   step_r, step_nxt;
  logic          hit_r, hit_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [CW-1:0] n_act;
  logic          in_acc, slot_free, both_done;

  assign n_act     = (int'(cfg.count) > MAX_ATTRACTORS) ? CW'(MAX_ATTRACTORS) : CW'(cfg.count);
  assign in_acc    = in_tvalid && (state_r == ST_IDLE);
  assign slot_free = !out_valid_r || out_tready;
  assign both_done = status.div_done && status.sqrt_done;

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    idx_nxt       = idx_r;
    step_nxt      = step_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_mode) begin
          state_nxt = ST_STEP;
          step_nxt  = '0;
        end
      end
      ST_STEP: begin
        if (step_r == cfg.limit) begin
          hit_nxt   = 1'b0;
          state_nxt = ST_DONE;
        end else begin
          k_nxt     = 2'd0;
          state_nxt = ST_V2;
        end
      end
      ST_V2: begin
        if (k_r == 2'd2) begin
          idx_nxt   = '0;
          state_nxt = ST_ATTR;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      ST_ATTR: begin
        k_nxt     = 2'd0;
        state_nxt = (idx_r == n_act) ? ST_DRAG : ST_DIR;
      end
      ST_DIR: state_nxt = ST_SQD;
      ST_SQD: begin
        if (k_r == 2'd2) begin
          state_nxt = ST_CHECK;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      ST_CHECK: begin
        if (status.capt) begin
          hit_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end else if (status.szero) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_ATTR;
        end else begin
          state_nxt = ST_MAGW;
        end
      end
      ST_MAGW: begin
        if (both_done) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        k_nxt     = 2'd0;
        state_nxt = ST_PMUL;
      end
      ST_PMUL: state_nxt = ST_PDIV;
      ST_PDIV: state_nxt = ST_PWAIT;
      ST_PWAIT: begin
        if (status.div_done) begin
          if (k_r == 2'd2) begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_ATTR;
          end else begin
            k_nxt     = k_r + 2'd1;
            state_nxt = ST_PMUL;
          end
        end
      end
      ST_DRAG: begin
        if (k_r == 2'd2) begin
          k_nxt     = 2'd0;
          state_nxt = ST_MOVE;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      ST_MOVE: begin
        if (k_r == 2'd2) begin
          step_nxt  = step_r + 16'd1;
          state_nxt = ST_STEP;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.k  = k_r;
    cmd.op = OP_NONE;
    case (state_r)
      ST_IDLE:  cmd.op = in_acc ? (in_mode ? OP_LOAD : OP_WRITE) : OP_NONE;
      ST_V2:    cmd.op = OP_SQ_V;
      ST_ATTR:  cmd.op = (idx_r != n_act) ? OP_RD : OP_NONE;
      ST_DIR:   cmd.op = OP_DIR;
      ST_SQD:   cmd.op = OP_SQ_D;
      ST_CHECK: cmd.op = (!status.capt && !status.szero) ? OP_START : OP_NONE;
      ST_MAGW:  cmd.op = both_done ? OP_MAG_SAVE : OP_NONE;
      ST_SCALE: cmd.op = OP_SCALE;
      ST_PMUL:  cmd.op = OP_PUSH_MUL;
      ST_PDIV:  cmd.op = OP_DIV_PUSH;
      ST_PWAIT: cmd.op = status.div_done ? OP_PUSH_APPLY : OP_NONE;
      ST_DRAG:  cmd.op = OP_DRAG;
      ST_MOVE:  cmd.op = OP_MOVE;
      ST_DONE:  cmd.op = slot_free ? (hit_r ? OP_RES_HIT : OP_RES_MISS) : OP_NONE;
      default:  cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      idx_r       <= '0;
      step_r      <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      idx_r       <= idx_nxt;
      step_r      <= step_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign rd_addr    = idx_r[IW-1:0];
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  a_res_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_RES_HIT || cmd.op == OP_RES_MISS) |-> (!out_valid_r || out_tready))
    else $error("result loaded over a pending result");

  a_pwait_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PWAIT) |-> ($past(state_r) == ST_PDIV || $past(state_r) == ST_PWAIT))
    else $error("push wait entered without a division start");

  a_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK && status.capt) |=> (state_r == ST_DONE && hit_r))
    else $error("capture did not lead to a hit result");

endmodule

### hw/rtl/attractor_basin_fate_predictor_top.sv
// Top level of the attractor basin fate predictor: ports, configuration registers, units.
// A load item (mode 0) writes one attractor table entry and gives no result. A predict
// item (mode 1) runs Euler steps until capture or until step_limit steps are done and
// then gives a valid result. The shared radix-2 divider serves the force magnitude and
// the three velocity components of every visit, while the square root runs beside the
// first division. One item is in work at a time; input is taken again while a finished
// result waits in the output register.
module attractor_basin_fate_predictor_top
  import abfp_pkg::*;
#(
  parameter int MAX_ATTRACTORS = MAX_ATTRACTORS_DEF,
  parameter int FRAC_BITS      = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // slot[2:0], coord_x[34:3], coord_y[66:35], coord_z[98:67], entry_color[130:99], zero pad
  input  logic [135:0] in_tdata,
  // mode[0]
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // fate_color[31:0]
  output logic [31:0]  out_tdata,
  // captured[0]
  output logic [0:0]   out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  localparam int IW = (MAX_ATTRACTORS > 1) ? $clog2(MAX_ATTRACTORS) : 1;

  cfg_t          cfg_r;
  cmd_t          cmd;
  status_t       status;
  logic [IW-1:0] rd_addr;
  logic [31:0]   out_color;
  logic          out_cap;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tick    <= 31'd167772;
      cfg_r.radius  <= 31'd16777;
      cfg_r.drag    <= 25'd16777216;
      cfg_r.force_k <= 31'd16777;
      cfg_r.count   <= 4'd0;
      cfg_r.limit   <= 16'd10000;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TICK:   cfg_r.tick    <= cfg_data[30:0];
        REG_RADIUS: cfg_r.radius  <= cfg_data[30:0];
        REG_DRAG:   cfg_r.drag    <= cfg_data[24:0];
        REG_FORCE:  cfg_r.force_k <= cfg_data[30:0];
        REG_COUNT:  cfg_r.count   <= cfg_data[3:0];
        REG_LIMIT:  cfg_r.limit   <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  abfp_ctrl #(
    .MAX_ATTRACTORS (MAX_ATTRACTORS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_mode    (in_tuser[0]),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg        (cfg_r),
    .status     (status),
    .cmd        (cmd),
    .rd_addr    (rd_addr)
  );

  abfp_dp #(
    .MAX_ATTRACTORS (MAX_ATTRACTORS),
    .FRAC_BITS      (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .rd_addr      (rd_addr),
    .cfg          (cfg_r),
    .in_slot      (in_tdata[2:0]),
    .in_x         (in_tdata[34:3]),
    .in_y         (in_tdata[66:35]),
    .in_z         (in_tdata[98:67]),
    .in_color     (in_tdata[130:99]),
    .out_color    (out_color),
    .out_captured (out_cap),
    .status       (status)
  );

  assign out_tdata    = out_color;
  assign out_tuser[0] = out_cap;

endmodule
